FILE: src/integer_text_formatter_defines.svh
// Assertion macros used by the checker of the integer text formatter.
// No dependencies; take it in by `include before the first assertion.
`ifndef INTEGER_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TEXT_FORMATTER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent; quiet while in reset.
`define ITF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define ITF_ASSERT_RESET(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/itf_pkg.sv
// Shared types and constants of the integer text formatter.
// No dependencies; used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps

package itf_pkg;

    localparam int unsigned DIG_N  = 22;             // octal needs 22 digits for 64 bits
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned DIGV_W = DIG_N * DIG_W;
    localparam int unsigned BCD_N  = 20;             // 2^64 fits in 20 decimal digits
    localparam int unsigned BCD_W  = BCD_N * DIG_W;

    localparam logic [5:0] WIDTH_MAX = 6'd40;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef logic [4:0] t_dig_idx;

    // One formatted number, ready to be spelled out.
    typedef struct packed {
        logic [DIGV_W-1:0] digits;   // digit i in bits [4i+3:4i], least significant first
        t_dig_idx          top;      // index of the most significant digit
        logic              has_sign;
        logic [7:0]        sign_ch;
        logic [5:0]        npad;
        logic [7:0]        fill;
        logic              pad_lead;
        logic              upper;
    } t_job;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } t_front_st;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SIGN,
        BK_LPAD,
        BK_DIG,
        BK_RPAD
    } t_back_st;

endpackage

FILE: src/itf_front.sv
// Front end: accepts a request, takes sign and magnitude, splits it into digits.
// Depends on itf_pkg.
`timescale 1ns / 1ps

module itf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [63:0]   i_value,
    input  logic [1:0]    i_radix_sel,
    input  logic [5:0]    i_field_width,
    input  logic [7:0]    i_fill_char,
    input  logic          i_fill_before,
    input  logic [7:0]    i_plus_char,
    input  logic          i_signed_mode,
    input  logic          i_upper_hex,
    output itf_pkg::t_job o_job,
    output logic          o_job_push,
    input  logic          i_q_full
);
    import itf_pkg::*;

    t_front_st         r_st, n_st;
    logic [63:0]       r_mag;
    logic [DIGV_W-1:0] r_dig;
    logic [3:0]        r_cnt;
    logic [5:0]        r_width;
    logic              r_has_sign;
    logic [7:0]        r_sign_ch;
    logic [7:0]        r_fill;
    logic              r_before;
    logic              r_upper;

    logic              accept;
    logic              neg;
    logic [63:0]       mag;
    logic [65:0]       mag_ext;
    logic [DIGV_W-1:0] oct_dig;
    t_dig_idx          top;
    logic [5:0]        used;
    logic [5:0]        npad;

    // Four shift-and-add-3 steps of binary to BCD conversion.
    function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] bcd,
                                                 input logic [3:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd;
        for (int s = 3; s >= 0; s--) begin
            for (int d = 0; d < BCD_N; d++) begin
                if (acc[d*DIG_W +: DIG_W] >= 4'd5) begin
                    acc[d*DIG_W +: DIG_W] = acc[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[s]};
        end
        return acc;
    endfunction

    assign accept  = (r_st == FR_IDLE) && i_push;
    assign neg     = i_signed_mode & i_value[63];
    assign mag     = neg ? (~i_value + 64'd1) : i_value;
    assign mag_ext = {2'b00, mag};

    always_comb begin
        for (int g = 0; g < DIG_N; g++) begin
            oct_dig[g*DIG_W +: DIG_W] = {1'b0, mag_ext[g*3 +: 3]};
        end
    end

    // Most significant nonzero digit; zero prints as one digit.
    always_comb begin
        top = '0;
        for (int i = 1; i < DIG_N; i++) begin
            if (r_dig[i*DIG_W +: DIG_W] != 4'd0) begin
                top = t_dig_idx'(i);
            end
        end
    end

    assign used = 6'(r_has_sign) + 6'(top) + 6'd1;
    assign npad = (r_width > used) ? (r_width - used) : 6'd0;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            FR_IDLE: begin
                if (accept) begin
                    n_st = (i_radix_sel == RADIX_DEC) ? FR_CONV : FR_PUSH;
                end
            end
            FR_CONV: begin
                if (r_cnt == 4'd0) begin
                    n_st = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!i_q_full) begin
                    n_st = FR_IDLE;
                end
            end
            default: n_st = FR_IDLE;
        endcase
    end

    always_comb begin
        o_full         = (r_st != FR_IDLE);
        o_job_push     = (r_st == FR_PUSH) && !i_q_full;
        o_job.digits   = r_dig;
        o_job.top      = top;
        o_job.has_sign = r_has_sign;
        o_job.sign_ch  = r_sign_ch;
        o_job.npad     = npad;
        o_job.fill     = r_fill;
        o_job.pad_lead = r_before;
        o_job.upper    = r_upper;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FR_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag      <= mag;
            r_cnt      <= '1;
            r_width    <= (i_field_width > WIDTH_MAX) ? WIDTH_MAX : i_field_width;
            r_has_sign <= neg || (i_plus_char != 8'd0);
            r_sign_ch  <= neg ? CH_MINUS : i_plus_char;
            r_fill     <= i_fill_char;
            r_before   <= i_fill_before;
            r_upper    <= i_upper_hex;
            unique case (i_radix_sel)
                RADIX_OCT: r_dig <= oct_dig;
                RADIX_DEC: r_dig <= '0;
                default:   r_dig <= {{(DIGV_W-64){1'b0}}, mag};
            endcase
        end else if (r_st == FR_CONV) begin
            r_dig[BCD_W-1:0] <= dabble4(r_dig[BCD_W-1:0], r_mag[63:60]);
            r_mag            <= {r_mag[59:0], 4'd0};
            r_cnt            <= r_cnt - 4'd1;
        end
    end

endmodule

FILE: src/itf_fifo.sv
// Two-entry queue of formatted numbers between front and back.
// Depends on itf_pkg.
`timescale 1ns / 1ps

module itf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output itf_pkg::t_job o_job,
    output logic          o_empty
);
    import itf_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

FILE: src/itf_back.sv
// Back end: spells one queued number out as characters into the output register.
// Depends on itf_pkg.
`timescale 1ns / 1ps

module itf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itf_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_text_char,
    output logic          o_last_char
);
    import itf_pkg::*;

    t_back_st     r_st, n_st;
    t_job         r_job;
    t_dig_idx     r_idx;
    logic [5:0]   r_pad;
    logic         r_out_valid;
    logic [7:0]   r_out_char;
    logic         r_out_last;

    logic         adv;
    logic         load;
    logic         emit;
    logic         pad_l;
    logic         pad_r;
    logic [3:0]   dig;
    logic [7:0]   dig_ch;
    logic [7:0]   ch;
    logic         last;

    assign adv   = !r_out_valid || i_pop;
    assign pad_l = r_job.pad_lead && (r_job.npad != 6'd0);
    assign pad_r = !r_job.pad_lead && (r_job.npad != 6'd0);
    assign dig   = r_job.digits[r_idx*DIG_W +: DIG_W];

    always_comb begin
        if (dig <= 4'd9) begin
            dig_ch = CH_ZERO + {4'd0, dig};
        end else begin
            dig_ch = (r_job.upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, dig} - 8'd10;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job.has_sign) begin
                        n_st = BK_SIGN;
                    end else if (i_job.pad_lead && (i_job.npad != 6'd0)) begin
                        n_st = BK_LPAD;
                    end else begin
                        n_st = BK_DIG;
                    end
                end
            end
            BK_SIGN: begin
                if (adv) begin
                    n_st = pad_l ? BK_LPAD : BK_DIG;
                end
            end
            BK_LPAD: begin
                if (adv && (r_pad == 6'd1)) begin
                    n_st = BK_DIG;
                end
            end
            BK_DIG: begin
                if (adv && (r_idx == '0)) begin
                    n_st = pad_r ? BK_RPAD : BK_IDLE;
                end
            end
            BK_RPAD: begin
                if (adv && (r_pad == 6'd1)) begin
                    n_st = BK_IDLE;
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        load = (r_st == BK_IDLE) && !i_q_empty;
        emit = adv && (r_st != BK_IDLE);
        ch   = r_job.fill;
        last = 1'b0;
        unique case (r_st)
            BK_IDLE: begin
                ch = r_job.fill;
            end
            BK_SIGN: begin
                ch = r_job.sign_ch;
            end
            BK_LPAD: begin
                ch = r_job.fill;
            end
            BK_DIG: begin
                ch   = dig_ch;
                last = (r_idx == '0) && !pad_r;
            end
            BK_RPAD: begin
                ch   = r_job.fill;
                last = (r_pad == 6'd1);
            end
            default: ch = r_job.fill;
        endcase
    end

    assign o_q_pop     = load;
    assign o_empty     = !r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
            r_idx <= i_job.top;
            r_pad <= i_job.npad;
        end else if (emit) begin
            if ((r_st == BK_LPAD) || (r_st == BK_RPAD)) begin
                r_pad <= r_pad - 6'd1;
            end
            if ((r_st == BK_DIG) && (r_idx != '0)) begin
                r_idx <= r_idx - t_dig_idx'(1);
            end
        end
        if (emit) begin
            r_out_char <= ch;
            r_out_last <= last;
        end
    end

endmodule

FILE: src/integer_text_formatter.sv
// Top level of the integer text formatter: front, two-entry queue and back.
// Depends on itf_pkg, itf_front, itf_fifo and itf_back.
//
//  Channel   Handshake          Payload
//  --------  -----------------  -----------------------------------------------------
//  request   push / full        i_value, i_radix_sel, i_field_width, i_fill_char,
//                               i_fill_before, i_plus_char, i_signed_mode, i_upper_hex
//  result    empty / pop        o_text_char, o_last_char (one character per result)
//
// Front: an octal or hex request goes straight to the push state; a decimal
//   one passes through the BCD converter first, four bits per cycle.
// Back: loads a number from the queue only when idle, then emits its
//   characters one at a time, holding while a result waits to be popped;
//   a number spells out as at most 40 characters.
// Reset: synchronous, active low; clears queue, state machines and result valid.
// Stalls: the queue lets the front convert the next request while the back
//   waits on pop; a held result stays on the ports until it is popped.
`timescale 1ns / 1ps

module integer_text_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_radix_sel,
    input  logic [5:0]  i_field_width,
    input  logic [7:0]  i_fill_char,
    input  logic        i_fill_before,
    input  logic [7:0]  i_plus_char,
    input  logic        i_signed_mode,
    input  logic        i_upper_hex,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_text_char,
    output logic        o_last_char
);
    import itf_pkg::*;

    t_job front_job;
    t_job q_job;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Front: take the request, fold in the sign, split the magnitude into digits.
    itf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_value       (i_value),
        .i_radix_sel   (i_radix_sel),
        .i_field_width (i_field_width),
        .i_fill_char   (i_fill_char),
        .i_fill_before (i_fill_before),
        .i_plus_char   (i_plus_char),
        .i_signed_mode (i_signed_mode),
        .i_upper_hex   (i_upper_hex),
        .o_job         (front_job),
        .o_job_push    (front_push),
        .i_q_full      (q_full)
    );

    // Hold up to two finished numbers so each side can stall on its own.
    itf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    // Back: sign, leading fill, digits and trailing fill, one per cycle unless held.
    itf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

FILE: src/itf_checker.sv
// Port-level checker for the integer text formatter, bound to the top level.
// Depends on integer_text_formatter_defines.svh and integer_text_formatter.
`timescale 1ns / 1ps
`include "integer_text_formatter_defines.svh"

module itf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_text_char,
    input logic       o_last_char
);

    // Reset leaves nothing to read and the request side open.
    `ITF_ASSERT_RESET(a_reset_clear, i_clk, !i_rst_n, empty && !full, "reset did not clear")

    // An accepted request leaves the front busy in the cycle after.
    `ITF_ASSERT_NEXT(a_push_busy, i_clk, i_rst_n, push && !full, full, "front took two requests")

    // A waiting result holds until popped.
    `ITF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_text_char) && $stable(o_last_char), "result changed while waiting")

endmodule

bind integer_text_formatter itf_checker u_itf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_text_char (o_text_char),
    .o_last_char (o_last_char)
);
